// File: hdl/assert_macros.svh
// Assertion macros shared by the decode and execute RTL.
// No dependencies; included inside module bodies that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rvde_pkg.sv
// Types and constants of the RV32IM subset decode and execute unit.
// No dependencies.
`default_nettype none
package rvde_pkg;

  localparam int unsigned XLEN_C = 32;

  localparam logic [4:0] OP_R      = 5'b01100;
  localparam logic [4:0] OP_IALU   = 5'b00100;
  localparam logic [4:0] OP_LOAD   = 5'b00000;
  localparam logic [4:0] OP_JALR   = 5'b11001;
  localparam logic [4:0] OP_STORE  = 5'b01000;
  localparam logic [4:0] OP_BRANCH = 5'b11000;
  localparam logic [4:0] OP_JAL    = 5'b11011;
  localparam logic [4:0] OP_LUI    = 5'b01101;
  localparam logic [4:0] OP_AUIPC  = 5'b00101;

  localparam logic [2:0] F3_EQ = 3'b000;
  localparam logic [2:0] F3_LT = 3'b100;

  typedef enum logic [3:0] {
    K_ADD, K_SUB, K_MUL, K_DIV, K_REM, K_XOR, K_OR, K_AND, K_SLL, K_SRA
  } alu_kind_t;

  typedef struct packed {
    logic        [31:0] instruction;
    logic        [31:0] pc_value;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
  } rvde_in_t;

  typedef struct packed {
    logic signed [31:0] alu_result;
    logic               redirect;
    logic        [31:0] redirect_target;
    logic               reg_write;
    logic               mem_read;
    logic               mem_write;
    logic        [4:0]  dest_reg;
    logic signed [31:0] store_data;
    logic               divide_by_zero;
  } rvde_out_t;

  // Everything that rides alongside the divider stages.
  typedef struct packed {
    rvde_out_t res;
    logic      use_div;
    logic      take_rem;
    logic      negate;
  } rvde_side_t;

endpackage
`default_nettype wire

// File: hdl/rvde_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on rvde_pkg.
`default_nettype none
module rvde_divider #(
  parameter int unsigned XLEN = rvde_pkg::XLEN_C
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [XLEN-1:0]         in_num,
  input  wire  [XLEN-1:0]         in_den,
  input  rvde_pkg::rvde_side_t    in_side,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [XLEN-1:0]         out_quo,
  output logic [XLEN-1:0]         out_rem,
  output rvde_pkg::rvde_side_t    out_side
);
  import rvde_pkg::*;

  logic [XLEN-1:0] rem_r  [XLEN];
  logic [XLEN-1:0] num_r  [XLEN];
  logic [XLEN-1:0] den_r  [XLEN];
  rvde_side_t      side_r [XLEN];
  logic [XLEN-1:0] v_r;
  logic [XLEN:0]   rdy;

  assign rdy[XLEN] = out_ready;
  assign in_ready  = rdy[0];

  for (genvar i = 0; i < XLEN; i++) begin : g_stage
    logic [XLEN-1:0] p_rem, p_num, p_den, rem_nxt, num_nxt;
    logic            p_v;
    rvde_side_t      p_side;
    logic [XLEN:0]   trial, diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign p_rem  = '0;
      assign p_num  = in_num;
      assign p_den  = in_den;
      assign p_side = in_side;
      assign p_v    = in_valid;
    end else begin : g_next
      assign p_rem  = rem_r[i-1];
      assign p_num  = num_r[i-1];
      assign p_den  = den_r[i-1];
      assign p_side = side_r[i-1];
      assign p_v    = v_r[i-1];
    end

    assign rdy[i]  = !v_r[i] || rdy[i+1];
    assign trial   = {p_rem, p_num[XLEN-1]};
    assign diff    = trial - {1'b0, p_den};
    assign ge      = (trial >= {1'b0, p_den});
    assign rem_nxt = ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
    assign num_nxt = {p_num[XLEN-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        rem_r[i]  <= rem_nxt;
        num_r[i]  <= num_nxt;
        den_r[i]  <= p_den;
        side_r[i] <= p_side;
      end
    end
  end

  assign out_valid = v_r[XLEN-1];
  assign out_quo   = num_r[XLEN-1];
  assign out_rem   = rem_r[XLEN-1];
  assign out_side  = side_r[XLEN-1];

endmodule
`default_nettype wire

// File: hdl/rv32_decode_execute.sv
// Top level of the RV32IM subset decode and execute unit.
// Depends on rvde_pkg, rvde_divider and assert_macros.svh.
`default_nettype none
// The unit takes one instruction beat per cycle while in_ready is high
// (instruction, PC and the two forwarded source values) and returns exactly
// one result beat for each, in order. Every beat takes the same path: a
// decode stage, an execute stage that holds the combinational multiplier and
// the adders, XLEN divider stages that each produce one quotient bit, and an
// output register, so the throughput is one beat per cycle without stalls.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so a stall on the result side fills the bubbles in front of
// it before in_ready falls, and nothing is dropped or repeated. Division by
// zero sets divide_by_zero and yields all ones for div and the dividend for
// rem; the most negative value divided by minus one gives itself, remainder 0.
module rv32_decode_execute #(
  parameter int unsigned XLEN = rvde_pkg::XLEN_C
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  rvde_pkg::rvde_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output rvde_pkg::rvde_out_t  out_data
);
  import rvde_pkg::*;
  `include "assert_macros.svh"

  typedef struct packed {
    alu_kind_t       kind;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] tgt;
    logic            is_branch;
    logic            is_jump;
    logic [2:0]      f3;
    logic            wr;
    logic            mr;
    logic            mw;
    logic [4:0]      rd;
    logic [XLEN-1:0] sd;
  } s1_t;

  // ------------------------------------------------------------------
  // Decode, operand selection and target address (input cycle).
  // ------------------------------------------------------------------
  logic [XLEN-1:0] ins, pc, r1, r2;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [4:0]      op;
  logic [2:0]      f3;
  alu_kind_t       imm_kind, r_kind;
  s1_t             s1_nxt, s1_r;
  logic            s1_v_r, s1_rdy;

  assign ins = in_data.instruction;
  assign pc  = in_data.pc_value;
  assign r1  = in_data.rs1_value;
  assign r2  = in_data.rs2_value;
  assign op  = ins[6:2];
  assign f3  = ins[14:12];

  assign imm_i = {{(XLEN-12){ins[31]}}, ins[31:20]};
  assign imm_s = {{(XLEN-12){ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{(XLEN-13){ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{(XLEN-21){ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'b0};

  always_comb begin
    case (f3)
      3'd0:    imm_kind = K_ADD;
      3'd4:    imm_kind = K_XOR;
      3'd6:    imm_kind = K_OR;
      3'd7:    imm_kind = K_AND;
      3'd1:    imm_kind = K_SLL;
      default: imm_kind = K_SRA;
    endcase
    r_kind = imm_kind;
    if (!ins[25]) begin
      // The subtract encoding of funct3 000 is read as add, and slt as subtract.
      case (f3)
        3'd2:    r_kind = K_SUB;
        3'd5:    r_kind = K_SRA;
        default: r_kind = imm_kind;
      endcase
    end else begin
      case (f3)
        3'd0:    r_kind = K_MUL;
        3'd4:    r_kind = K_DIV;
        3'd6:    r_kind = K_REM;
        default: r_kind = imm_kind;
      endcase
    end
  end

  always_comb begin
    logic [XLEN-1:0] tb, to;
    s1_nxt           = '0;
    s1_nxt.kind      = K_ADD;
    s1_nxt.a         = r1;
    s1_nxt.b         = imm_u;
    s1_nxt.f3        = f3;
    s1_nxt.wr        = 1'b1;
    s1_nxt.rd        = ins[11:7];
    s1_nxt.sd        = r2;
    tb               = pc;
    to               = imm_b;
    case (op)
      OP_R: begin
        s1_nxt.b    = r2;
        s1_nxt.kind = r_kind;
      end
      OP_IALU: begin
        s1_nxt.b    = imm_i;
        s1_nxt.kind = imm_kind;
      end
      OP_LOAD: begin
        s1_nxt.b  = imm_i;
        s1_nxt.mr = 1'b1;
      end
      OP_STORE: begin
        s1_nxt.b  = imm_s;
        s1_nxt.mw = 1'b1;
        s1_nxt.wr = 1'b0;
      end
      OP_BRANCH: begin
        s1_nxt.b         = r2;
        s1_nxt.kind      = K_SUB;
        s1_nxt.wr        = 1'b0;
        s1_nxt.is_branch = 1'b1;
      end
      OP_JAL: begin
        s1_nxt.a       = pc;
        s1_nxt.b       = XLEN'(4);
        s1_nxt.is_jump = 1'b1;
        to             = imm_j;
      end
      OP_JALR: begin
        s1_nxt.a       = pc;
        s1_nxt.b       = XLEN'(4);
        s1_nxt.is_jump = 1'b1;
        tb             = r1;
        to             = imm_i;
      end
      OP_LUI: begin
        s1_nxt.a = '0;
      end
      OP_AUIPC: begin
        s1_nxt.a = pc;
      end
      default: begin
        // Unknown opcodes behave as a U-type add onto rs1.
        s1_nxt.b = imm_u;
      end
    endcase
    s1_nxt.tgt = tb + to;
    if (!s1_nxt.wr) begin
      s1_nxt.rd = '0;
    end
    if (!s1_nxt.mw) begin
      s1_nxt.sd = '0;
    end
  end

  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_r <= s1_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Execute: ALU, multiplier, branch decision and divider set-up.
  // ------------------------------------------------------------------
  logic [XLEN-1:0] alu_res, mul_res, ua, ub;
  logic [4:0]      shamt;
  logic            dz, br_taken, is_dr;
  rvde_side_t      s2_side_nxt, s2_side_r;
  logic [XLEN-1:0] s2_num_r, s2_den_r;
  logic            s2_v_r, s2_rdy, div_in_ready;

  assign shamt   = s1_r.b[4:0];
  assign mul_res = s1_r.a * s1_r.b;
  assign is_dr   = (s1_r.kind == K_DIV) || (s1_r.kind == K_REM);
  assign dz      = is_dr && (s1_r.b == '0);
  assign ua      = s1_r.a[XLEN-1] ? (~s1_r.a + 1'b1) : s1_r.a;
  assign ub      = s1_r.b[XLEN-1] ? (~s1_r.b + 1'b1) : s1_r.b;

  always_comb begin
    case (s1_r.kind)
      K_ADD:   alu_res = s1_r.a + s1_r.b;
      K_SUB:   alu_res = s1_r.a - s1_r.b;
      K_MUL:   alu_res = mul_res;
      K_XOR:   alu_res = s1_r.a ^ s1_r.b;
      K_OR:    alu_res = s1_r.a | s1_r.b;
      K_AND:   alu_res = s1_r.a & s1_r.b;
      K_SLL:   alu_res = s1_r.a << shamt;
      K_SRA:   alu_res = XLEN'($signed(s1_r.a) >>> shamt);
      K_DIV:   alu_res = '1;
      K_REM:   alu_res = s1_r.a;
      default: alu_res = s1_r.a;
    endcase
  end

  assign br_taken = s1_r.is_branch &&
                    (((s1_r.f3 == F3_EQ) && (alu_res == '0)) ||
                     ((s1_r.f3 == F3_LT) && alu_res[XLEN-1]));

  always_comb begin
    s2_side_nxt                    = '0;
    s2_side_nxt.res.alu_result     = alu_res;
    s2_side_nxt.res.redirect       = s1_r.is_jump || br_taken;
    s2_side_nxt.res.redirect_target = (s1_r.is_jump || br_taken) ? s1_r.tgt : '0;
    s2_side_nxt.res.reg_write      = s1_r.wr;
    s2_side_nxt.res.mem_read       = s1_r.mr;
    s2_side_nxt.res.mem_write      = s1_r.mw;
    s2_side_nxt.res.dest_reg       = s1_r.rd;
    s2_side_nxt.res.store_data     = s1_r.sd;
    s2_side_nxt.res.divide_by_zero = dz;
    // A zero divisor is settled here; the divider result is then ignored.
    s2_side_nxt.use_div            = is_dr && !dz;
    s2_side_nxt.take_rem           = (s1_r.kind == K_REM);
    s2_side_nxt.negate             = (s1_r.kind == K_REM) ? s1_r.a[XLEN-1]
                                                          : (s1_r.a[XLEN-1] ^ s1_r.b[XLEN-1]);
  end

  assign s1_rdy = !s1_v_r || s2_rdy;
  assign s2_rdy = !s2_v_r || div_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_side_r <= s2_side_nxt;
      s2_num_r  <= ua;
      s2_den_r  <= ub;
    end
  end

  // ------------------------------------------------------------------
  // Divider stages; every beat passes through them.
  // ------------------------------------------------------------------
  logic            div_out_valid, out_rdy;
  logic [XLEN-1:0] div_quo, div_rem, mag, fixed;
  rvde_side_t      div_side;
  rvde_out_t       out_nxt, out_r;
  logic            out_v_r;

  rvde_divider #(.XLEN(XLEN)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_ready  (div_in_ready),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_side   (s2_side_r),
    .out_valid (div_out_valid),
    .out_ready (out_rdy),
    .out_quo   (div_quo),
    .out_rem   (div_rem),
    .out_side  (div_side)
  );

  // Sign correction of the quotient or remainder, then the output register.
  assign mag   = div_side.take_rem ? div_rem : div_quo;
  assign fixed = div_side.negate ? (~mag + 1'b1) : mag;

  always_comb begin
    out_nxt = div_side.res;
    if (div_side.use_div) begin
      out_nxt.alu_result = fixed;
    end
  end

  assign out_rdy = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  `ASSERT_IMPLIES(a_rd_zero, out_valid && !out_data.reg_write, out_data.dest_reg == 5'd0, "dest_reg set without reg_write")
  `ASSERT_IMPLIES(a_tgt_zero, out_valid && !out_data.redirect, out_data.redirect_target == '0, "target set without redirect")
  `ASSERT_IMPLIES(a_dz_rtype, out_valid && out_data.divide_by_zero, out_data.reg_write && !out_data.mem_read && !out_data.mem_write, "divide by zero outside an R-type beat")
  `ASSERT_NEXT(a_s2_hold, s2_v_r && !div_in_ready, s2_v_r && $stable(s2_side_r), "execute stage lost a stalled beat")

endmodule
`default_nettype wire
